// File: hdl/wide_decimal_narrow_round_assert.svh
// Assertion macros shared by the decimal narrowing block.
`ifndef WIDE_DECIMAL_NARROW_ROUND_ASSERT_SVH
`define WIDE_DECIMAL_NARROW_ROUND_ASSERT_SVH

// Same-cycle implication.
`define WDNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wdnr assertion failed");

// Next-cycle implication.
`define WDNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wdnr assertion failed");

`endif

// File: hdl/wdnr_pkg.sv
// Package: widths, constants, codes and shared types of the decimal narrowing block.
package wdnr_pkg;

  localparam int MANT_WORDS = 7;
  localparam int WORD_W     = 32;
  localparam int MANT_W     = MANT_WORDS * WORD_W;
  localparam int KEEP_W     = 96;
  localparam int LOW_W      = 64;
  localparam int HIGH_W     = KEEP_W - LOW_W;
  localparam int EXP_W      = 6;
  localparam int SCALE_W    = 5;
  localparam int REM_W      = 4;
  localparam int CNT_W      = 3;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int DEF_MAX_SCALE = 28;

  // ceil(2^35 / 10): exact quotient for dividends below 2^34
  localparam int RECIP_SHIFT = 35;
  localparam logic [WORD_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  // floor(2^32 / 10); 2^32 mod 10 is 6
  localparam logic [WORD_W-1:0] WORD_QUOT = 32'h1999_9999;
  localparam int                WORD_REM  = 6;

  localparam logic [REM_W-1:0] HALF_DIGIT = 4'd5;

  localparam logic [MODE_W-1:0] MODE_EVEN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF_UP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRUNC   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POS_OVF = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NEG_OVF = 2'd2;

  localparam logic REG_ROUNDING_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } wdnr_state_t;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic div_step;
    logic round_step;
    logic load_out;
  } wdnr_cmd_t;

  typedef struct packed {
    logic need_step;
    logic out_free;
  } wdnr_sts_t;

endpackage

// File: hdl/wdnr_div10.sv
// One 32-bit digit of a long division by ten, remainder in and out.
module wdnr_div10 (
  input  logic [wdnr_pkg::REM_W-1:0]  rem_in,
  input  logic [wdnr_pkg::WORD_W-1:0] word_in,
  output logic [wdnr_pkg::WORD_W-1:0] quot,
  output logic [wdnr_pkg::REM_W-1:0]  rem_out
);
  import wdnr_pkg::*;

  localparam int Y_W = WORD_W + 1;
  localparam int P_W = Y_W + WORD_W;
  localparam int Q_W = P_W - RECIP_SHIFT;

  logic [Y_W-1:0] y;
  logic [P_W-1:0] prod;
  logic [Q_W-1:0] q_lo;
  logic [Y_W-1:0] back;

  // rem*2^32 + w = 10*(rem*WORD_QUOT) + (rem*6 + w)
  assign y       = Y_W'(rem_in) * Y_W'(WORD_REM) + Y_W'(word_in);
  assign prod    = P_W'(y) * P_W'(RECIP_TEN);
  assign q_lo    = prod[P_W-1:RECIP_SHIFT];
  assign back    = (Y_W'(q_lo) << 3) + (Y_W'(q_lo) << 1);
  assign rem_out = REM_W'(y - back);
  assign quot    = WORD_W'(rem_in) * WORD_QUOT + WORD_W'(q_lo);

endmodule

// File: hdl/wdnr_ctrl.sv
// Controller: sequences load, divide-by-ten steps, rounding and result hand-off.
`include "wide_decimal_narrow_round_assert.svh"

module wdnr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wdnr_pkg::wdnr_sts_t sts,
  output wdnr_pkg::wdnr_cmd_t cmd
);
  import wdnr_pkg::*;

  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(MANT_WORDS - 1);

  wdnr_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (sts.need_step) begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_WORD) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        state_nxt      = ST_CHECK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `WDNR_ASSERT_NXT(a_round_then_check, clk, rst_n, state_r == ST_ROUND, state_r == ST_CHECK)
  `WDNR_ASSERT_NXT(a_div_len, clk, rst_n, state_r == ST_DIV && cnt_r == LAST_WORD, state_r == ST_ROUND)
  `WDNR_ASSERT_IMP(a_out_free, clk, rst_n, cmd.load_out, sts.out_free)

endmodule

// File: hdl/wdnr_dp.sv
// Datapath: mantissa shift register, word divider, rounding and result register.
`include "wide_decimal_narrow_round_assert.svh"

module wdnr_dp #(
  parameter int MAX_SCALE = wdnr_pkg::DEF_MAX_SCALE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wdnr_pkg::wdnr_cmd_t          cmd,
  output wdnr_pkg::wdnr_sts_t          sts,
  input  logic [wdnr_pkg::MODE_W-1:0]  mode,
  input  logic [wdnr_pkg::MANT_W-1:0]  in_mant,
  input  logic [wdnr_pkg::EXP_W-1:0]   in_exponent,
  input  logic                         in_negative,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wdnr_pkg::LOW_W-1:0]   out_result_low,
  output logic [wdnr_pkg::HIGH_W-1:0]  out_result_high,
  output logic [wdnr_pkg::SCALE_W-1:0] out_result_scale,
  output logic                         out_result_negative,
  output logic [wdnr_pkg::STAT_W-1:0]  out_status
);
  import wdnr_pkg::*;

  logic [MANT_W-1:0]  mant_r, mant_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [EXP_W-1:0]   exp_r, exp_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LOW_W-1:0]   low_r;
  logic [HIGH_W-1:0]  high_r;
  logic [SCALE_W-1:0] scale_r;
  logic               oneg_r;
  logic [STAT_W-1:0]  stat_r;

  logic [WORD_W-1:0]  quot;
  logic [REM_W-1:0]   dig_rem;
  logic               upper, zero, inc;

  wdnr_div10 u_div10 (
    .rem_in  (rem_r),
    .word_in (mant_r[MANT_W-1 -: WORD_W]),
    .quot    (quot),
    .rem_out (dig_rem)
  );

  assign upper = |mant_r[MANT_W-1:KEEP_W];
  assign zero  = ~|mant_r[KEEP_W-1:0];

  assign sts.need_step = (exp_r > EXP_W'(MAX_SCALE)) || (upper && (exp_r != '0));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (mode)
      MODE_EVEN:    inc = (rem_r > HALF_DIGIT) || ((rem_r == HALF_DIGIT) && mant_r[0]);
      MODE_HALF_UP: inc = (rem_r >= HALF_DIGIT);
      default:      inc = 1'b0;
    endcase
  end

  always_comb begin
    mant_nxt = mant_r;
    rem_nxt  = rem_r;
    exp_nxt  = exp_r;
    neg_nxt  = neg_r;
    if (cmd.load_in) begin
      mant_nxt = in_mant;
      exp_nxt  = in_exponent;
      neg_nxt  = in_negative;
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
    end
    if (cmd.div_step) begin
      mant_nxt = {mant_r[MANT_W-WORD_W-1:0], quot};
      rem_nxt  = dig_rem;
    end
    if (cmd.round_step) begin
      mant_nxt = mant_r + MANT_W'(inc);
      exp_nxt  = exp_r - EXP_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mant_r <= mant_nxt;
    rem_r  <= rem_nxt;
    exp_r  <= exp_nxt;
    neg_r  <= neg_nxt;
    if (cmd.load_out) begin
      low_r   <= upper ? '0 : mant_r[LOW_W-1:0];
      high_r  <= upper ? '0 : mant_r[KEEP_W-1:LOW_W];
      scale_r <= (upper || zero) ? '0 : exp_r[SCALE_W-1:0];
      oneg_r  <= !upper && !zero && neg_r;
      stat_r  <= !upper ? STAT_OK : (neg_r ? STAT_NEG_OVF : STAT_POS_OVF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_low      = low_r;
  assign out_result_high     = high_r;
  assign out_result_scale    = scale_r;
  assign out_result_negative = oneg_r;
  assign out_status          = stat_r;

  `WDNR_ASSERT_IMP(a_step_nonzero_exp, clk, rst_n, cmd.round_step, exp_r != '0)
  `WDNR_ASSERT_IMP(a_ovf_clears, clk, rst_n, out_valid_r && stat_r != STAT_OK, low_r == '0 && high_r == '0 && scale_r == '0 && !oneg_r)
  `WDNR_ASSERT_IMP(a_zero_canon, clk, rst_n, out_valid_r && low_r == '0 && high_r == '0, scale_r == '0 && !oneg_r)

endmodule

// File: hdl/wide_decimal_narrow_round.sv
// Each request runs N divide-by-ten steps (N = 0..63) between request accept and result valid.
// Each step passes the seven mantissa words through the 32-bit divide unit, then a rounding state and a check.
// Requests are taken only while the controller is idle. The result register frees the input side.
// Reset (synchronous, rst_n low): controller idle, no result pending, rounding_mode half-even.
// Top level: configuration register, controller and datapath of the decimal narrowing block.
module wide_decimal_narrow_round #(
  parameter int MAX_SCALE = wdnr_pkg::DEF_MAX_SCALE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word0,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word1,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word2,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word3,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word4,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word5,
  input  logic [wdnr_pkg::WORD_W-1:0]  in_mant_word6,
  input  logic [wdnr_pkg::EXP_W-1:0]   in_exponent,
  input  logic                         in_negative,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wdnr_pkg::LOW_W-1:0]   out_result_low,
  output logic [wdnr_pkg::HIGH_W-1:0]  out_result_high,
  output logic [wdnr_pkg::SCALE_W-1:0] out_result_scale,
  output logic                         out_result_negative,
  output logic [wdnr_pkg::STAT_W-1:0]  out_status,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wdnr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [wdnr_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [wdnr_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import wdnr_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              reg_sel;
  wdnr_cmd_t         cmd;
  wdnr_sts_t         sts;

  assign reg_sel    = cfg_paddr[ADDR_W-1];
  assign cfg_pready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (reg_sel == REG_ROUNDING_MODE)) begin
      mode_nxt = cfg_pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROUNDING_MODE: cfg_prdata = DATA_W'(mode_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EVEN;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  wdnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wdnr_dp #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .mode                (mode_r),
    .in_mant             ({in_mant_word6, in_mant_word5, in_mant_word4, in_mant_word3,
                           in_mant_word2, in_mant_word1, in_mant_word0}),
    .in_exponent         (in_exponent),
    .in_negative         (in_negative),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_low      (out_result_low),
    .out_result_high     (out_result_high),
    .out_result_scale    (out_result_scale),
    .out_result_negative (out_result_negative),
    .out_status          (out_status)
  );

endmodule
